[design/wrms_pkg.sv]
// Shared types and constants for the windowed RMS level meter.
// No dependencies; every other design file refers to this package by scoped names.
package wrms_pkg;

   // Sample and level widths
   localparam int LEVEL_W      = 10;
   localparam int LEVEL_MAX    = 1023;
   localparam int ROOT_W       = 10;

   // Defaults for the top-level parameter and the CSR reset values
   localparam int WINDOW_DEFAULT = 10;
   localparam int CENTRE_RESET   = 458;

   // Queue between front and back
   localparam int QUEUE_DEPTH  = 2;

   // CSR map: register index is paddr[2]
   localparam int PADDR_W      = 3;
   localparam int PDATA_W      = 32;
   localparam logic CSR_FOLD_ENABLE = 1'b0;
   localparam logic CSR_FOLD_CENTRE = 1'b1;

   // One folded sample written into the queue
   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
   } q_push_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
   } q_head_type;

endpackage

[design/windowed_rms_level_meter.sv]
// Windowed RMS level meter top level: CSR/front end, sample queue, back end.
// Depends on wrms_pkg, wrms_front, wrms_queue and wrms_back.
//
// Each transferred sample is folded about fold_centre (when fold_enable is set),
// pushed into a two-entry queue and then processed by the back end: the pop
// reads the oldest window entry and writes the new one, the S_OLDSQ, S_NEWSQ and
// S_ADD states square and update the running sum, S_ROOT runs the one-bit-per-cycle
// square root of sum/WINDOW, and S_DONE loads the output register once it is free.
// The back-end sequencer works on one item at a time; the queue accepts up to two
// samples ahead of it, and a result waits in the output register while the next
// item is worked on. The window reads as zero after reset through per-entry valid
// bits, so there is no clearing pass.
// CSRs: fold_enable at byte address 0, fold_centre at byte address 4.
module windowed_rms_level_meter #(
   parameter int WINDOW = wrms_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wrms_pkg::LEVEL_W-1:0]  req_sample,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wrms_pkg::LEVEL_W-1:0]  rsp_rms_level,
   // CSR port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wrms_pkg::PADDR_W-1:0]  paddr,
   input  logic [wrms_pkg::PDATA_W-1:0]  pwdata,
   output logic [wrms_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   wrms_pkg::q_push_type q_push;
   wrms_pkg::q_head_type q_head;
   logic                 q_full;
   logic                 q_pop;

   wrms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .q_full     (q_full),
      .q_push     (q_push)
   );

   wrms_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   wrms_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rms_level (rsp_rms_level)
   );

endmodule

[design/wrms_front.sv]
// Front end: input transfer, CSR block and sample folding.
// Depends on wrms_pkg; feeds wrms_queue.
module wrms_front (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wrms_pkg::LEVEL_W-1:0]  req_sample,
   // CSR port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wrms_pkg::PADDR_W-1:0]  paddr,
   input  logic [wrms_pkg::PDATA_W-1:0]  pwdata,
   output logic [wrms_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   // queue side
   input  logic                          q_full,
   output wrms_pkg::q_push_type          q_push
);

   logic                          fold_enable_ff, fold_enable_in;
   logic [wrms_pkg::LEVEL_W-1:0]  fold_centre_ff, fold_centre_in;
   logic                          csr_wr;
   logic [wrms_pkg::LEVEL_W:0]    mirror;
   logic [wrms_pkg::LEVEL_W-1:0]  folded;

   // CSR write decode
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      fold_enable_in = fold_enable_ff;
      fold_centre_in = fold_centre_ff;
      if (csr_wr) begin
         case (paddr[2])
            wrms_pkg::CSR_FOLD_ENABLE: fold_enable_in = pwdata[0];
            wrms_pkg::CSR_FOLD_CENTRE: fold_centre_in = pwdata[wrms_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_enable_ff <= 1'b1;
         fold_centre_ff <= wrms_pkg::LEVEL_W'(wrms_pkg::CENTRE_RESET);
      end else begin
         fold_enable_ff <= fold_enable_in;
         fold_centre_ff <= fold_centre_in;
      end
   end

   // CSR read mux
   always_comb begin
      prdata = '0;
      case (paddr[2])
         wrms_pkg::CSR_FOLD_ENABLE: prdata[0] = fold_enable_ff;
         wrms_pkg::CSR_FOLD_CENTRE: prdata[wrms_pkg::LEVEL_W-1:0] = fold_centre_ff;
         default: prdata = '0;
      endcase
   end

   // Fold (when enabled): at or below centre mirrors to 2*centre - sample, saturating
   assign mirror = {fold_centre_ff, 1'b0} - {1'b0, req_sample};

   always_comb begin
      folded = req_sample;
      if (fold_enable_ff && (req_sample <= fold_centre_ff)) begin
         if (mirror > (wrms_pkg::LEVEL_W+1)'(wrms_pkg::LEVEL_MAX))
            folded = wrms_pkg::LEVEL_W'(wrms_pkg::LEVEL_MAX);
         else
            folded = mirror[wrms_pkg::LEVEL_W-1:0];
      end
   end

   // Transfer into the queue whenever it has room
   assign req_ready    = ~q_full;
   assign q_push.valid = req_valid & ~q_full;
   assign q_push.level = folded;

endmodule

[design/wrms_queue.sv]
// Short FIFO of folded samples between the front and back ends.
// Depends on wrms_pkg.
module wrms_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  wrms_pkg::q_push_type  q_push,
   output logic                  q_full,
   input  logic                  q_pop,
   output wrms_pkg::q_head_type  q_head
);

   localparam int PTR_W = (wrms_pkg::QUEUE_DEPTH > 1) ? $clog2(wrms_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(wrms_pkg::QUEUE_DEPTH + 1);

   logic [wrms_pkg::LEVEL_W-1:0] slot_ff [wrms_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         do_push, do_pop;

   assign q_full       = (count_ff == CNT_W'(wrms_pkg::QUEUE_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.level = slot_ff[rd_ptr_ff];

   assign do_push = q_push.valid & ~q_full;
   assign do_pop  = q_pop & q_head.valid;

   // pointer wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(wrms_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(wrms_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= q_push.level;
   end

endmodule

[design/wrms_back.sv]
// Back end: window memory, running square sum, scaled square root, output register.
// Depends on wrms_pkg; pops from wrms_queue.
module wrms_back #(
   parameter int WINDOW = wrms_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wrms_pkg::q_head_type          q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wrms_pkg::LEVEL_W-1:0]  rsp_rms_level
);

   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int SUM_MAX = WINDOW * wrms_pkg::LEVEL_MAX * wrms_pkg::LEVEL_MAX;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);
   localparam int RW      = SUM_W + 2;
   localparam int PROD_W  = 2 * wrms_pkg::LEVEL_W;
   localparam logic [RW-1:0] D_INIT = RW'(WINDOW) << (2 * (wrms_pkg::ROOT_W - 1));

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_OLDSQ = 6'b000010,
      S_NEWSQ = 6'b000100,
      S_ADD   = 6'b001000,
      S_ROOT  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;

   // window memory with per-entry valid bits (unwritten entries read as zero)
   logic [wrms_pkg::LEVEL_W-1:0]  mem [WINDOW];
   logic [WINDOW-1:0]             mem_vld_ff;
   logic [wrms_pkg::LEVEL_W-1:0]  rd_data_ff;
   logic                          rd_vld_ff;
   logic [SLOT_W-1:0]             slot_ff;
   logic [wrms_pkg::LEVEL_W-1:0]  new_ff;

   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [wrms_pkg::LEVEL_W-1:0]  old_level;

   // square root datapath: acc = W*root^2, cross = W*root<<(k+1), dsq = W<<2k
   logic [RW-1:0]                 acc_ff, acc_in;
   logic [RW-1:0]                 cross_ff, cross_in;
   logic [RW-1:0]                 dsq_ff, dsq_in;
   logic [wrms_pkg::ROOT_W-1:0]   bit_ff, bit_in;
   logic [wrms_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [RW-1:0]                 cand;
   logic [RW-1:0]                 cross_upd;
   logic                          fits;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wrms_pkg::LEVEL_W-1:0]  rsp_level_ff;
   logic                          out_free;
   logic                          load_out;

   assign q_pop     = (state_ff == S_IDLE) & q_head.valid;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign load_out  = (state_ff == S_DONE) & out_free;
   assign old_level = rd_vld_ff ? rd_data_ff : '0;

   // root trial: W*(root|bit)^2 against the sum
   assign cand      = acc_ff + cross_ff + dsq_ff;
   assign fits      = (cand <= RW'(sum_ff));
   assign cross_upd = fits ? (cross_ff + {dsq_ff[RW-2:0], 1'b0}) : cross_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      cross_in = cross_ff;
      dsq_in   = dsq_ff;
      bit_in   = bit_ff;
      root_in  = root_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_head.valid)
               state_in = S_OLDSQ;
         end
         S_OLDSQ: begin
            prod_in  = old_level * old_level;
            state_in = S_NEWSQ;
         end
         S_NEWSQ: begin
            sum_in   = sum_ff - SUM_W'(prod_ff);
            prod_in  = new_ff * new_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            sum_in   = sum_ff + SUM_W'(prod_ff);
            acc_in   = '0;
            cross_in = '0;
            dsq_in   = D_INIT;
            bit_in   = {1'b1, {(wrms_pkg::ROOT_W-1){1'b0}}};
            root_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (fits) begin
               acc_in  = cand;
               root_in = root_ff | bit_ff;
            end
            cross_in = cross_upd >> 1;
            dsq_in   = dsq_ff >> 2;
            bit_in   = bit_ff >> 1;
            if (bit_ff[0])
               state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         slot_ff      <= '0;
         mem_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            mem_vld_ff[slot_ff] <= 1'b1;
            slot_ff <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      cross_ff <= cross_in;
      dsq_ff   <= dsq_in;
      bit_ff   <= bit_in;
      root_ff  <= root_in;
      if (q_pop) begin
         new_ff    <= q_head.level;
         rd_vld_ff <= mem_vld_ff[slot_ff];
      end
      if (load_out)
         rsp_level_ff <= root_ff;
   end

   // window memory: read oldest and write newest at the same slot
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff   <= mem[slot_ff];
         mem[slot_ff] <= q_head.level;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rms_level = rsp_level_ff;

   // slot pointer stays inside the window
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("window slot out of range");

   // running sum never exceeds a full window of maximum samples
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(SUM_MAX))
      else $error("square sum out of range");

   // accepted root trials never pass the sum
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (acc_ff <= RW'(sum_ff)))
      else $error("root accumulator above sum");

   // a finished result shows up on the output next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_valid_ff && rsp_level_ff == $past(root_ff)))
      else $error("result not loaded");

   // every pop starts an item in S_OLDSQ
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_OLDSQ))
      else $error("pop outside idle");

endmodule
